/* rtl/core/wnst_pkg.sv */
`timescale 1ns / 1ps

package wnst_pkg;

   // Table size and the widths that follow from it.
   localparam int MAX_SECTIONS = 64;
   localparam int SEC_W = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;
   localparam int CNT_W = SEC_W + 1;

   // Biased power distance: two 64-bit squares plus a 52-bit weight bias.
   localparam int PWR_W = 66;

   // Serial multiplier operand, product and bit-count widths.
   localparam int MUL_AW = 96;
   localparam int MUL_PW = 2 * MUL_AW;
   localparam int MUL_NW = 7;

   // One seed as held by a ring cell.
   typedef struct packed {
      logic [31:0] x;
      logic [31:0] y;
      logic [50:0] w;
   } seed_type;

   // Result of the power pipeline for one seed.
   typedef struct packed {
      logic             valid;
      logic [SEC_W-1:0] idx;
      logic [PWR_W-1:0] p;
      logic [31:0]      x;
      logic [31:0]      y;
   } pw_type;

   // Command to the serial multiplier.
   typedef struct packed {
      logic              start;
      logic [MUL_NW-1:0] nbits;
   } mul_cmd_type;

endpackage

/* rtl/core/wnst_cell.sv */
`timescale 1ns / 1ps

module wnst_cell (
   input  logic               clock,
   input  logic               load,
   input  logic               shift,
   input  wnst_pkg::seed_type wr_seed,
   input  wnst_pkg::seed_type nb_seed,
   output wnst_pkg::seed_type seed
);
   import wnst_pkg::*;

   seed_type seed_ff;

   // A write loads the cell; during a sweep it takes its neighbor's seed.
   always_ff @(posedge clock) begin
      if (load) begin
         seed_ff <= wr_seed;
      end else if (shift) begin
         seed_ff <= nb_seed;
      end
   end

   assign seed = seed_ff;

endmodule

/* rtl/core/wnst_power.sv */
`timescale 1ns / 1ps

module wnst_power (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   input  logic [wnst_pkg::SEC_W-1:0] in_idx,
   input  logic [31:0]                px,
   input  logic [31:0]                py,
   input  wnst_pkg::seed_type         seed,
   output wnst_pkg::pw_type           result
);
   import wnst_pkg::*;

   logic signed [32:0] dx;
   logic signed [32:0] dy;
   logic signed [52:0] bias;

   logic             v1_ff, v2_ff, v3_ff;
   logic [SEC_W-1:0] idx1_ff, idx2_ff, idx3_ff;
   logic [31:0]      x1_ff, x2_ff, x3_ff;
   logic [31:0]      y1_ff, y2_ff, y3_ff;
   logic [31:0]      mx1_ff, my1_ff;
   logic [51:0]      bias1_ff, bias2_ff;
   logic [63:0]      sx2_ff, sy2_ff;
   logic [PWR_W-1:0] p3_ff;

   // Differences to the sample and the weight turned into a positive bias.
   always_comb begin
      dx   = $signed({px[31], px}) - $signed({seed.x[31], seed.x});
      dy   = $signed({py[31], py}) - $signed({seed.y[31], seed.y});
      bias = (53'sd1 <<< 50) - 53'($signed(seed.w));
   end

   // Valid bits of the three stages.
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   // Stage one magnitudes, stage two squares, stage three the sum.
   always_ff @(posedge clock) begin
      idx1_ff  <= in_idx;
      x1_ff    <= seed.x;
      y1_ff    <= seed.y;
      mx1_ff   <= dx[32] ? 32'(-dx) : 32'(dx);
      my1_ff   <= dy[32] ? 32'(-dy) : 32'(dy);
      bias1_ff <= bias[51:0];

      idx2_ff  <= idx1_ff;
      x2_ff    <= x1_ff;
      y2_ff    <= y1_ff;
      sx2_ff   <= 64'(mx1_ff) * 64'(mx1_ff);
      sy2_ff   <= 64'(my1_ff) * 64'(my1_ff);
      bias2_ff <= bias1_ff;

      idx3_ff  <= idx2_ff;
      x3_ff    <= x2_ff;
      y3_ff    <= y2_ff;
      p3_ff    <= PWR_W'(sx2_ff) + PWR_W'(sy2_ff) + PWR_W'(bias2_ff);
   end

   assign result.valid = v3_ff;
   assign result.idx   = idx3_ff;
   assign result.p     = p3_ff;
   assign result.x     = x3_ff;
   assign result.y     = y3_ff;

endmodule

/* rtl/core/wnst_mul.sv */
`timescale 1ns / 1ps

module wnst_mul (
   input  logic                        clock,
   input  logic                        reset,
   input  wnst_pkg::mul_cmd_type       cmd,
   input  logic [wnst_pkg::MUL_AW-1:0] a,
   input  logic [wnst_pkg::MUL_AW-1:0] b,
   output logic                        done,
   output logic [wnst_pkg::MUL_PW-1:0] p
);
   import wnst_pkg::*;

   logic              run_ff;
   logic              done_ff;
   logic [MUL_NW-1:0] cnt_ff;
   logic [MUL_PW-1:0] a_ff;
   logic [MUL_AW-1:0] b_ff;
   logic [MUL_PW-1:0] p_ff;

   // Shift-and-add, one multiplier bit per cycle.
   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (cmd.start) begin
            run_ff <= 1'b1;
         end else if (run_ff && cnt_ff == MUL_NW'(1)) begin
            run_ff  <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         a_ff   <= MUL_PW'(a);
         b_ff   <= b;
         p_ff   <= '0;
         cnt_ff <= cmd.nbits;
      end else if (run_ff) begin
         if (b_ff[0]) begin
            p_ff <= p_ff + a_ff;
         end
         a_ff   <= a_ff << 1;
         b_ff   <= b_ff >> 1;
         cnt_ff <= cnt_ff - MUL_NW'(1);
      end
   end

   assign done = done_ff;
   assign p    = p_ff;

endmodule

/* rtl/core/weighted_nearest_section_tracker.sv */
`timescale 1ns / 1ps

// Nearest-section tracker over a power diagram of up to MAX_SECTIONS seeds with
// hysteresis. Seeds live in a ring of cells that rotates once past a shared
// power pipeline per position sample. A seed write or a forget is done without
// leaving the idle state. When the nearest seed differs from the held one and
// has a lower power, a bit-serial multiplier works out the squared margin test
// in up to six passes of 32, 32, 27, 93, 16 and 32 bits. A result may wait on
// rsp_ready while the next transaction is accepted. Configuration is written
// through csr_we/csr_index.
module weighted_nearest_section_tracker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_func,
   input  logic [5:0]  req_seed_index,
   input  logic [31:0] req_seed_px,
   input  logic [31:0] req_seed_py,
   input  logic [50:0] req_seed_wt,
   input  logic [31:0] req_lon,
   input  logic [31:0] req_lat,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [5:0]  rsp_section,
   output logic        rsp_changed,
   output logic [5:0]  rsp_nearest,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [16:0] csr_wdata
);
   import wnst_pkg::*;

   localparam logic [1:0] FUNC_WRITE  = 2'd0;
   localparam logic [1:0] FUNC_SAMPLE = 2'd1;
   localparam logic [1:0] FUNC_FORGET = 2'd2;

   localparam logic [1:0] CSR_COUNT = 2'd0;
   localparam logic [1:0] CSR_SCALE = 2'd1;
   localparam logic [1:0] CSR_HOLD  = 2'd2;

   localparam logic [26:0] MM_PER_DEG = 27'd111320000;

   typedef enum logic [3:0] {
      ST_IDLE, ST_PROD, ST_SCALE, ST_SWEEP, ST_DRAIN, ST_DECIDE,
      ST_GX, ST_GY, ST_LM, ST_LL, ST_HH, ST_RH, ST_CMP, ST_OUT
   } state_type;

   state_type state_ff;

   // Configuration.
   logic [6:0]  count_ff;
   logic [16:0] scale_ff;
   logic [15:0] hold_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 7'd1;
         scale_ff <= 17'd65536;
         hold_ff  <= 16'd8000;
      end else if (csr_we) begin
         case (csr_index)
            CSR_COUNT: count_ff <= csr_wdata[6:0];
            CSR_SCALE: scale_ff <= csr_wdata;
            CSR_HOLD:  hold_ff  <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   // Effective seed count, clamped to one through the table size.
   logic [CNT_W-1:0] n_eff;

   always_comb begin
      if (count_ff == 7'd0) begin
         n_eff = CNT_W'(1);
      end else if (int'(count_ff) > MAX_SECTIONS) begin
         n_eff = CNT_W'(MAX_SECTIONS);
      end else begin
         n_eff = CNT_W'(count_ff);
      end
   end

   logic req_fire;
   logic wr_en;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign wr_en     = req_fire && (req_func == FUNC_WRITE);

   // Seed ring: each cell hands its seed to the one below during a sweep.
   seed_type ring_q [MAX_SECTIONS];
   seed_type wr_seed;

   assign wr_seed.x = req_seed_px;
   assign wr_seed.y = req_seed_py;
   assign wr_seed.w = req_seed_wt;

   for (genvar k = 0; k < MAX_SECTIONS; k++) begin : g_cell
      localparam int NB = (k + 1) % MAX_SECTIONS;
      wnst_cell u_cell (
         .clock   (clock),
         .load    (wr_en && (int'(req_seed_index) == k)),
         .shift   (state_ff == ST_SWEEP),
         .wr_seed (wr_seed),
         .nb_seed (ring_q[NB]),
         .seed    (ring_q[k])
      );
   end

   // Sample position and its scaled longitude.
   logic signed [31:0] lon_ff;
   logic [31:0]        lat_ff;
   logic signed [49:0] prod_ff;
   logic [31:0]        px_ff;
   logic signed [50:0] rnd;
   logic signed [34:0] shr;
   logic [31:0]        px_in;

   always_comb begin
      rnd = 51'(prod_ff) + 51'sd32768;
      shr = 35'(rnd >>> 16);
      if (shr > 35'sd2147483647) begin
         px_in = 32'h7fffffff;
      end else if (shr < -35'sd2147483648) begin
         px_in = 32'h80000000;
      end else begin
         px_in = shr[31:0];
      end
   end

   // Power pipeline fed from the head of the ring.
   logic [SEC_W-1:0] iss_ff;
   pw_type           pw;

   wnst_power u_power (
      .clock    (clock),
      .reset    (reset),
      .in_valid ((state_ff == ST_SWEEP) && (CNT_W'(iss_ff) < n_eff)),
      .in_idx   (iss_ff),
      .px       (px_ff),
      .py       (lat_ff),
      .seed     (ring_q[0]),
      .result   (pw)
   );

   // Running minimum and capture of the held seed.
   logic [PWR_W-1:0] best_ff, ph_ff;
   logic [SEC_W-1:0] near_ff, held_ff;
   logic [31:0]      nx_ff, ny_ff, hx_ff, hy_ff;

   always_ff @(posedge clock) begin
      if (pw.valid && (pw.idx == '0 || pw.p < best_ff)) begin
         best_ff <= pw.p;
         near_ff <= pw.idx;
         nx_ff   <= pw.x;
         ny_ff   <= pw.y;
      end
      if (pw.valid && pw.idx == held_ff) begin
         ph_ff <= pw.p;
         hx_ff <= pw.x;
         hy_ff <= pw.y;
      end
   end

   // Decision datapath.
   logic [PWR_W-1:0]   d_ff;
   logic [31:0]        gxm_ff, gym_ff;
   logic [63:0]        gx2_ff;
   logic [64:0]        gap2_ff;
   logic [92:0]        l_ff;
   logic [185:0]       ll_ff;
   logic [31:0]        h_ff;
   logic [SEC_W-1:0]   next_ff;
   logic               have_ff;
   logic [1:0]         drain_ff;
   logic signed [32:0] gx, gy;
   logic               adopt;
   logic               switch_gt;

   // Serial multiplier for the switch test.
   mul_cmd_type       mul_cmd;
   logic [MUL_AW-1:0] mul_a, mul_b;
   logic              mul_done;
   logic [MUL_PW-1:0] mul_p;
   logic              issued_ff;

   always_comb begin
      mul_a         = '0;
      mul_b         = '0;
      mul_cmd.nbits = MUL_NW'(32);
      case (state_ff)
         ST_GX: begin
            mul_a = MUL_AW'(gxm_ff);
            mul_b = MUL_AW'(gxm_ff);
         end
         ST_GY: begin
            mul_a = MUL_AW'(gym_ff);
            mul_b = MUL_AW'(gym_ff);
         end
         ST_LM: begin
            mul_a         = MUL_AW'(d_ff);
            mul_b         = MUL_AW'(MM_PER_DEG);
            mul_cmd.nbits = MUL_NW'(27);
         end
         ST_LL: begin
            mul_a         = MUL_AW'(l_ff);
            mul_b         = MUL_AW'(l_ff);
            mul_cmd.nbits = MUL_NW'(93);
         end
         ST_HH: begin
            mul_a         = MUL_AW'(hold_ff);
            mul_b         = MUL_AW'(hold_ff);
            mul_cmd.nbits = MUL_NW'(16);
         end
         ST_RH: begin
            mul_a = MUL_AW'(gap2_ff);
            mul_b = MUL_AW'(h_ff);
         end
         default: ;
      endcase
      mul_cmd.start = !issued_ff && (state_ff == ST_GX || state_ff == ST_GY ||
                      state_ff == ST_LM || state_ff == ST_LL ||
                      state_ff == ST_HH || state_ff == ST_RH);
   end

   wnst_mul u_mul (
      .clock (clock),
      .reset (reset),
      .cmd   (mul_cmd),
      .a     (mul_a),
      .b     (mul_b),
      .done  (mul_done),
      .p     (mul_p)
   );

   always_comb begin
      gx        = $signed({nx_ff[31], nx_ff}) - $signed({hx_ff[31], hx_ff});
      gy        = $signed({ny_ff[31], ny_ff}) - $signed({hy_ff[31], hy_ff});
      adopt     = !have_ff || (CNT_W'(held_ff) >= n_eff);
      switch_gt = ll_ff > 186'({mul_p[96:0], 46'd0});
   end

   logic             rsp_valid_ff;
   logic [5:0]       rsp_section_ff, rsp_nearest_ff;
   logic             rsp_changed_ff;

   // Sequencer with the held section and the result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         held_ff      <= '0;
         have_ff      <= 1'b0;
         issued_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         iss_ff       <= '0;
         drain_ff     <= '0;
      end else begin
         // In the output step the result register is handled below.
         if (rsp_ready && state_ff != ST_OUT) begin
            rsp_valid_ff <= 1'b0;
         end
         if (mul_cmd.start) begin
            issued_ff <= 1'b1;
         end
         if (mul_done) begin
            issued_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_fire && req_func == FUNC_SAMPLE) begin
                  lon_ff   <= $signed(req_lon);
                  lat_ff   <= req_lat;
                  state_ff <= ST_PROD;
               end else if (req_fire && req_func == FUNC_FORGET) begin
                  have_ff <= 1'b0;
               end
            end
            ST_PROD: begin
               prod_ff  <= 50'(lon_ff) * 50'($signed({1'b0, scale_ff}));
               state_ff <= ST_SCALE;
            end
            ST_SCALE: begin
               px_ff    <= px_in;
               iss_ff   <= '0;
               state_ff <= ST_SWEEP;
            end
            ST_SWEEP: begin
               iss_ff <= iss_ff + SEC_W'(1);
               if (iss_ff == SEC_W'(MAX_SECTIONS - 1)) begin
                  drain_ff <= '0;
                  state_ff <= ST_DRAIN;
               end
            end
            ST_DRAIN: begin
               drain_ff <= drain_ff + 2'd1;
               if (drain_ff == 2'd2) begin
                  state_ff <= ST_DECIDE;
               end
            end
            ST_DECIDE: begin
               d_ff   <= ph_ff - best_ff;
               gxm_ff <= gx[32] ? 32'(-gx) : 32'(gx);
               gym_ff <= gy[32] ? 32'(-gy) : 32'(gy);
               if (adopt) begin
                  next_ff  <= near_ff;
                  state_ff <= ST_OUT;
               end else if (near_ff == held_ff || ph_ff == best_ff) begin
                  next_ff  <= held_ff;
                  state_ff <= ST_OUT;
               end else begin
                  state_ff <= ST_GX;
               end
            end
            ST_GX: begin
               if (mul_done) begin
                  gx2_ff   <= mul_p[63:0];
                  state_ff <= ST_GY;
               end
            end
            ST_GY: begin
               if (mul_done) begin
                  gap2_ff <= 65'(gx2_ff) + 65'(mul_p[63:0]);
                  if (gx2_ff == 64'd0 && mul_p[63:0] == 64'd0) begin
                     next_ff  <= near_ff;
                     state_ff <= ST_OUT;
                  end else begin
                     state_ff <= ST_LM;
                  end
               end
            end
            ST_LM: begin
               if (mul_done) begin
                  l_ff     <= mul_p[92:0];
                  state_ff <= ST_LL;
               end
            end
            ST_LL: begin
               if (mul_done) begin
                  ll_ff    <= mul_p[185:0];
                  state_ff <= ST_HH;
               end
            end
            ST_HH: begin
               if (mul_done) begin
                  h_ff     <= mul_p[31:0];
                  state_ff <= ST_RH;
               end
            end
            ST_RH: begin
               if (mul_done) begin
                  state_ff <= ST_CMP;
               end
            end
            ST_CMP: begin
               next_ff  <= switch_gt ? near_ff : held_ff;
               state_ff <= ST_OUT;
            end
            ST_OUT: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_valid_ff   <= 1'b1;
                  rsp_section_ff <= 6'(next_ff);
                  rsp_nearest_ff <= 6'(near_ff);
                  rsp_changed_ff <= !have_ff || (next_ff != held_ff);
                  held_ff        <= next_ff;
                  have_ff        <= 1'b1;
                  state_ff       <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_section = rsp_section_ff;
   assign rsp_changed = rsp_changed_ff;
   assign rsp_nearest = rsp_nearest_ff;

   // A pending result always names the section now held.
   a_rsp_held : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_section_ff == 6'(held_ff))
      else $error("pending result disagrees with held section");

   // The multiplier only finishes inside a switch-test step.
   a_mul_state : assert property (@(posedge clock) disable iff (reset)
      mul_done |-> (state_ff == ST_GX || state_ff == ST_GY || state_ff == ST_LM ||
                    state_ff == ST_LL || state_ff == ST_HH || state_ff == ST_RH))
      else $error("multiplier finished outside a test step");

   // The decision only follows a full pipeline drain.
   a_decide : assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DECIDE |-> $past(state_ff) == ST_DRAIN)
      else $error("decision reached without draining the pipeline");

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps

module testbench;
   import wnst_pkg::*;

   // Request selector and register codes.
   localparam logic [1:0] FN_WRITE  = 2'd0;
   localparam logic [1:0] FN_SAMPLE = 2'd1;
   localparam logic [1:0] FN_FORGET = 2'd2;
   localparam logic [1:0] FN_UNUSED = 2'd3;
   localparam logic [1:0] CSR_COUNT = 2'd0;
   localparam logic [1:0] CSR_SCALE = 2'd1;
   localparam logic [1:0] CSR_HOLD  = 2'd2;

   localparam logic [255:0] MM_PER_DEG = 256'd111320000;
   localparam int DRAIN_CYCLES = 400;
   localparam int RANDOM_ITEMS = 530;

   typedef struct {
      logic [1:0]  fn;
      logic [5:0]  idx;
      logic [31:0] px;
      logic [31:0] py;
      logic [50:0] wt;
      logic [31:0] lon;
      logic [31:0] lat;
      bit          typed;
      logic [5:0]  sec;
      bit          chg;
      logic [5:0]  near;
   } stim_row_type;

   typedef struct {
      logic [5:0] sec;
      logic       chg;
      logic [5:0] near;
   } section_report_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_func = '0;
   logic [5:0]  req_seed_index = '0;
   logic [31:0] req_seed_px = '0;
   logic [31:0] req_seed_py = '0;
   logic [50:0] req_seed_wt = '0;
   logic [31:0] req_lon = '0;
   logic [31:0] req_lat = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [5:0]  rsp_section;
   logic        rsp_changed;
   logic [5:0]  rsp_nearest;
   logic        csr_we = 1'b0;
   logic [1:0]  csr_index = '0;
   logic [16:0] csr_wdata = '0;

   weighted_nearest_section_tracker dut (.*);

   always #5 clock = ~clock;

   // Model state: seed table, held section and register copies.
   longint      seed_x [MAX_SECTIONS];
   longint      seed_y [MAX_SECTIONS];
   longint      seed_w [MAX_SECTIONS];
   bit          seed_loaded [MAX_SECTIONS];
   int          held_sec = 0;
   bit          holding = 0;
   int          count_reg = 1;
   longint      scale_reg = 65536;
   longint      hold_reg = 8000;

   section_report_type reports_due[$];
   stim_row_type       directed_rows[$];
   int  mismatches = 0;
   int  reports_seen = 0;
   int  switches_seen = 0;
   int  stall_left = 0;
   bit  quiet = 0;

   // Append one row to the directed table.
   function automatic void add_row(stim_row_type r);
      directed_rows = {directed_rows, r};
   endfunction

   // Power distance of seed k from a planar point, exact in 128 bits.
   function automatic logic signed [127:0] power_of(longint px, longint py, int k);
      logic signed [127:0] dx;
      logic signed [127:0] dy;
      dx = px - seed_x[k];
      dy = py - seed_y[k];
      return dx * dx + dy * dy - 128'(seed_w[k]);
   endfunction

   // Effective number of seeds in use.
   function automatic int seeds_in_use();
      if (count_reg < 1) return 1;
      if (count_reg > MAX_SECTIONS) return MAX_SECTIONS;
      return count_reg;
   endfunction

   // Work out the section report for an accepted transaction; 0 if none.
   function automatic bit track_item(stim_row_type r, output section_report_type rep);
      longint px;
      longint py;
      int n;
      int near;
      int nxt;
      logic signed [127:0] best;
      logic signed [127:0] p;
      logic [255:0] d;
      logic [255:0] gap2;
      logic signed [127:0] gx;
      logic signed [127:0] gy;
      rep = '{default: '0};
      if (r.fn == FN_WRITE) begin
         seed_x[r.idx] = longint'($signed(r.px));
         seed_y[r.idx] = longint'($signed(r.py));
         seed_w[r.idx] = longint'($signed(r.wt));
         return 0;
      end
      if (r.fn == FN_FORGET) begin
         holding = 0;
         return 0;
      end
      if (r.fn != FN_SAMPLE) return 0;
      n = seeds_in_use();
      // Planar x: round half up, then saturate to 32 bits.
      px = (longint'($signed(r.lon)) * scale_reg + 32768) >>> 16;
      if (px > 64'sd2147483647) px = 64'sd2147483647;
      if (px < -64'sd2147483648) px = -64'sd2147483648;
      py = longint'($signed(r.lat));
      near = 0;
      best = power_of(px, py, 0);
      for (int k = 1; k < n; k++) begin
         p = power_of(px, py, k);
         if (p < best) begin
            best = p;
            near = k;
         end
      end
      // Hysteresis: switch only if the margin past the boundary beats the hold.
      if (!holding || held_sec >= n) begin
         nxt = near;
      end else if (near == held_sec) begin
         nxt = held_sec;
      end else begin
         d = 256'(power_of(px, py, held_sec) - best);
         gx = seed_x[near] - seed_x[held_sec];
         gy = seed_y[near] - seed_y[held_sec];
         gap2 = 256'(gx * gx + gy * gy);
         nxt = held_sec;
         if (d != 0) begin
            if (gap2 == 0) nxt = near;
            else if (d * d * MM_PER_DEG * MM_PER_DEG >
                     ((256'(4 * hold_reg * hold_reg) * gap2) << 44)) nxt = near;
         end
      end
      rep.chg = !holding || nxt != held_sec;
      rep.sec = nxt[5:0];
      rep.near = near[5:0];
      held_sec = nxt;
      holding = 1;
      return 1;
   endfunction

   // Drive one transaction, wait for acceptance, then record its report.
   task automatic send(stim_row_type r);
      int gap;
      section_report_type rep;
      gap = (quiet || $urandom_range(0, 3) != 0) ? 0 : $urandom_range(1, 14);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_func <= r.fn;
      req_seed_index <= r.idx;
      req_seed_px <= r.px;
      req_seed_py <= r.py;
      req_seed_wt <= r.wt;
      req_lon <= r.lon;
      req_lat <= r.lat;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (r.fn == FN_WRITE) seed_loaded[r.idx] = 1;
      if (track_item(r, rep)) begin
         if (r.typed) begin
            rep.sec = r.sec;
            rep.chg = r.chg;
            rep.near = r.near;
         end
         reports_due = {reports_due, rep};
      end
   endtask

   // Let the block go idle: all reports in, then its longest latency.
   task automatic drain();
      req_valid <= 1'b0;
      while (reports_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Write the three registers on consecutive cycles.
   task automatic write_regs(int cnt, longint scl, longint hld);
      csr_we <= 1'b1;
      csr_index <= CSR_COUNT;
      csr_wdata <= 17'(cnt);
      @(posedge clock);
      csr_index <= CSR_SCALE;
      csr_wdata <= 17'(scl);
      @(posedge clock);
      csr_index <= CSR_HOLD;
      csr_wdata <= 17'(hld);
      @(posedge clock);
      csr_we <= 1'b0;
      count_reg = cnt;
      scale_reg = scl;
      hold_reg = hld;
   endtask

   function automatic stim_row_type row(logic [1:0] fn, logic [5:0] idx, logic [31:0] px,
                                        logic [31:0] py, logic [50:0] wt, logic [31:0] lon,
                                        logic [31:0] lat);
      stim_row_type r;
      r = '{default: '0};
      r.fn = fn; r.idx = idx; r.px = px; r.py = py; r.wt = wt; r.lon = lon; r.lat = lat;
      return r;
   endfunction

   function automatic stim_row_type typed_row(stim_row_type r, logic [5:0] sec, bit chg,
                                              logic [5:0] near);
      r.typed = 1; r.sec = sec; r.chg = chg; r.near = near;
      return r;
   endfunction

   // Random transaction: mostly writes and samples inside a small cluster so
   // that samples fall near the dividing lines, plus full-range noise.
   task automatic send_random(longint cx, longint cy);
      stim_row_type r;
      int n;
      int sel;
      int miss;
      longint lx;
      n = seeds_in_use();
      miss = -1;
      for (int k = n - 1; k >= 0; k--) if (!seed_loaded[k]) miss = k;
      sel = $urandom_range(0, 99);
      r = row(FN_WRITE, 6'($urandom_range(0, n - 1)), 32'(cx + $urandom_range(0, 6000) - 3000),
              32'(cy + $urandom_range(0, 6000) - 3000),
              51'($signed(32'($urandom_range(0, 33554432))) - 16777216), 0, 0);
      if (miss >= 0) begin
         r.idx = 6'(miss);
      end else if (sel < 58) begin
         lx = cx + $urandom_range(0, 7000) - 3500;
         if (scale_reg != 0) lx = (lx * 65536) / scale_reg;
         if (lx > 64'sd2147483647) lx = 64'sd2147483647;
         if (lx < -64'sd2147483648) lx = -64'sd2147483648;
         r = row(FN_SAMPLE, 6'($urandom), 32'($urandom), 32'($urandom), 51'({$urandom, $urandom}),
                 32'(lx), 32'(cy + $urandom_range(0, 7000) - 3500));
      end else if (sel < 72) begin
         r.lon = $urandom;
      end else if (sel < 77) begin
         r = row(FN_FORGET, 6'($urandom), $urandom, $urandom, 51'({$urandom, $urandom}),
                 $urandom, $urandom);
      end else if (sel < 81) begin
         r = row(FN_UNUSED, 6'($urandom), $urandom, $urandom, 51'({$urandom, $urandom}),
                 $urandom, $urandom);
      end else if (sel < 91) begin
         r = row(FN_SAMPLE, 6'($urandom), $urandom, $urandom, 51'({$urandom, $urandom}),
                 $urandom, $urandom);
      end else begin
         r = row(FN_WRITE, 6'($urandom), $urandom, $urandom, 51'({$urandom, $urandom}),
                 $urandom, $urandom);
      end
      send(r);
   endtask

   // Result side: check each transaction and stall in random bursts.
   always @(posedge clock) begin
      section_report_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (reports_due.size() == 0) begin
            $display("%0t: unexpected report section=%0d changed=%0d nearest=%0d",
                     $time, rsp_section, rsp_changed, rsp_nearest);
            mismatches++;
         end else begin
            want = reports_due.pop_front();
            reports_seen++;
            if (rsp_changed) switches_seen++;
            if (rsp_section !== want.sec) begin
               $display("%0t: section expected %0d actual %0d", $time, want.sec, rsp_section);
               mismatches++;
            end
            if (rsp_changed !== want.chg) begin
               $display("%0t: changed expected %0d actual %0d", $time, want.chg, rsp_changed);
               mismatches++;
            end
            if (rsp_nearest !== want.near) begin
               $display("%0t: nearest expected %0d actual %0d", $time, want.near, rsp_nearest);
               mismatches++;
            end
         end
      end
      if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else if (quiet || $urandom_range(0, 5) != 0) begin
         rsp_ready <= 1'b1;
      end else begin
         stall_left = $urandom_range(1, 14) - 1;
         rsp_ready <= 1'b0;
      end
   end

   // Overall time limit.
   initial begin
      #20ms;
      $display("Test completed with failures");
      $finish;
   end

   // Main sequence.
   initial begin
      int counts [6];
      longint scales [6];
      longint holds [6];
      longint cx;
      longint cy;
      int sent;

      counts = '{64, 0, 100, 2, 37, 127};
      scales = '{65536, 0, 131071, 46341, 65536, 32768};
      holds = '{8000, 40000, 65535, 0, 20000, 8000};

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed, reset settings: a single seed at the extremes.
      add_row(row(FN_WRITE, 0, 32'h7FFFFFFF, 32'h80000000, 51'h3FFFFFFFFFFFF, 0, 0));
      add_row(typed_row(row(FN_SAMPLE, 0, 0, 0, 0, 32'h80000000, 32'h7FFFFFFF), 0, 1, 0));
      add_row(typed_row(row(FN_SAMPLE, 0, 0, 0, 0, 32'h7FFFFFFF, 32'h80000000), 0, 0, 0));
      add_row(row(FN_FORGET, 0, 0, 0, 0, 0, 0));
      add_row(typed_row(row(FN_SAMPLE, 0, 0, 0, 0, 0, 0), 0, 1, 0));
      add_row(row(FN_UNUSED, 6'h3F, '1, '1, '1, '1, '1));
      add_row(row(FN_WRITE, 0, 0, 0, 51'h4000000000000, 0, 0));
      add_row(typed_row(row(FN_SAMPLE, 0, 0, 0, 0, 0, 0), 0, 0, 0));
      foreach (directed_rows[i]) send(directed_rows[i]);
      drain();

      // Four seeds: ties, zero gap with and without a margin.
      write_regs(4, 65536, 8000);
      directed_rows.delete();
      add_row(row(FN_WRITE, 0, 0, 0, 0, 0, 0));
      add_row(row(FN_WRITE, 1, 0, 0, 0, 0, 0));
      add_row(row(FN_WRITE, 2, 1000, 0, 0, 0, 0));
      add_row(row(FN_WRITE, 3, 1000, 0, 0, 0, 0));
      add_row(row(FN_FORGET, 0, 0, 0, 0, 0, 0));
      add_row(typed_row(row(FN_SAMPLE, 0, 0, 0, 0, 1000, 0), 2, 1, 2));
      add_row(row(FN_WRITE, 3, 1000, 0, 100, 0, 0));
      add_row(row(FN_SAMPLE, 0, 0, 0, 0, 1000, 0));
      add_row(row(FN_WRITE, 2, 1000, 0, 100, 0, 0));
      add_row(row(FN_SAMPLE, 0, 0, 0, 0, 1000, 0));
      foreach (directed_rows[i]) begin
         seed_loaded[directed_rows[i].idx] |= (directed_rows[i].fn == FN_WRITE);
         send(directed_rows[i]);
      end
      drain();

      // Held section no longer below the count: nearest is adopted.
      write_regs(2, 65536, 8000);
      send(typed_row(row(FN_SAMPLE, 0, 0, 0, 0, 1000, 0), 0, 1, 0));
      drain();

      // Random phases over several register settings.
      sent = 0;
      for (int ph = 0; ph < 6; ph++) begin
         write_regs(counts[ph], scales[ph], holds[ph]);
         cx = longint'($signed($urandom)) >>> 2;
         cy = longint'($signed($urandom)) >>> 2;
         for (int i = 0; i < RANDOM_ITEMS / 6; i++) begin
            if (sent > RANDOM_ITEMS * 17 / 20) quiet = 1;
            send_random(cx, cy);
            sent++;
         end
         drain();
      end

      $display("Checked %0d section reports (%0d with a change) over %0d random transactions,",
               reports_seen, switches_seen, sent);
      $display("across nine register settings including count, scale and hold extremes.");
      if (mismatches == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
